// ----- src/lz78_pkg.sv -----
package lz78_pkg;

	localparam int DictDepthDef = 4096;
	localparam int MaxPhraseDef = 64;

	localparam int IdxW  = 16;
	localparam int ByteW = 8;

	typedef struct packed {
		logic [IdxW-1:0]  idx;
		logic [ByteW-1:0] ch;
		logic             clear;
	} lz78_tok_t;

endpackage

// ----- src/lz78_front.sv -----
module lz78_front
	import lz78_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [IdxW-1:0]      prefix_index,
	input  logic [ByteW-1:0]     new_char,
	input  logic                 new_stream,
	output logic                 tok_valid,
	input  logic                 tok_take,
	output lz78_tok_t            tok
);

	localparam int QDepth = 2;

	lz78_tok_t  fifo_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full      = (cnt_q == 2'(QDepth));
	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = fifo_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = tok_take && tok_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wp_q] <= '{idx: prefix_index, ch: new_char, clear: new_stream};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> cnt_q != 2'd0) else $error("full queue drained without pop");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("empty queue pointers differ");

endmodule

// ----- src/lz78_back.sv -----
module lz78_back
	import lz78_pkg::*;
#(
	parameter int DICT_DEPTH = DictDepthDef,
	parameter int MAX_PHRASE = MaxPhraseDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	output logic             tok_take,
	input  lz78_tok_t        tok,
	output logic             empty,
	input  logic             pop,
	output logic [ByteW-1:0] out_byte,
	output logic             last,
	output logic             phrase_error
);

	localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
	localparam int CW = $clog2(DICT_DEPTH + 1);
	localparam int LW = $clog2(MAX_PHRASE + 1);
	localparam int SW = (MAX_PHRASE > 1) ? $clog2(MAX_PHRASE) : 1;

	typedef enum logic [2:0] {S_IDLE, S_LEN, S_WALK, S_WAIT, S_EMIT, S_ERR} st_t;

	logic [AW-1:0]    mem_pre [DICT_DEPTH];
	logic [ByteW-1:0] mem_chr [DICT_DEPTH];
	logic [LW-1:0]    mem_len [DICT_DEPTH];
	logic [ByteW-1:0] stk [MAX_PHRASE];

	st_t              st_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    link_q, rd_addr;
	logic             known_q;
	logic [ByteW-1:0] ch_q;
	logic [LW-1:0]    total_q, pos_q, k_q;
	logic [AW-1:0]    rd_pre_q;
	logic [ByteW-1:0] rd_chr_q, stk_rd_q;
	logic [LW-1:0]    rd_len_q;
	logic [SW-1:0]    stk_ra;
	logic             out_v_q;
	logic [CW-1:0]    cnt_eff;
	logic             known_c;
	logic             err_c;
	logic [LW-1:0]    total_c;
	logic             out_load;

	assign cnt_eff = tok.clear ? '0 : count_q;
	assign known_c = (tok.idx != '0) && (32'(tok.idx) <= 32'(cnt_eff));
	assign tok_take = (st_q == S_IDLE) && tok_valid;
	assign rd_addr  = (st_q == S_IDLE) ? AW'(32'(tok.idx) - 1) :
			(st_q == S_LEN) ? link_q : rd_pre_q;
	assign stk_ra   = SW'(k_q);
	assign err_c    = known_q && (32'(rd_len_q) + 1 > MAX_PHRASE);
	assign total_c  = known_q ? rd_len_q + 1'b1 : LW'(1);
	assign out_load = ((st_q == S_EMIT) || (st_q == S_ERR)) && (!out_v_q || pop);

	always_ff @(posedge clk) begin
		rd_pre_q <= mem_pre[rd_addr];
		rd_chr_q <= mem_chr[rd_addr];
		rd_len_q <= mem_len[rd_addr];
		stk_rd_q <= stk[stk_ra];
		if (st_q == S_WALK && pos_q != '0) begin
			stk[SW'(pos_q - 1'b1)] <= rd_chr_q;
		end else if (st_q == S_LEN && !err_c) begin
			stk[SW'(total_c - 1'b1)] <= ch_q;
		end
		if (st_q == S_LEN && !err_c && 32'(count_q) < DICT_DEPTH) begin
			mem_pre[AW'(count_q)] <= link_q;
			mem_chr[AW'(count_q)] <= ch_q;
			mem_len[AW'(count_q)] <= total_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			count_q      <= '0;
			out_v_q      <= 1'b0;
			last         <= 1'b0;
			phrase_error <= 1'b0;
			out_byte     <= '0;
			link_q       <= '0;
			known_q      <= 1'b0;
			ch_q         <= '0;
			total_q      <= '0;
			pos_q        <= '0;
			k_q          <= '0;
		end else begin
			out_v_q <= out_load || (out_v_q && !pop);
			unique case (st_q)
				S_IDLE: begin
					if (tok_valid) begin
						count_q <= cnt_eff;
						link_q  <= AW'(32'(tok.idx) - 1);
						known_q <= known_c;
						ch_q    <= tok.ch;
						st_q    <= S_LEN;
					end
				end
				S_LEN: begin
					if (err_c) begin
						st_q <= S_ERR;
					end else begin
						total_q <= total_c;
						pos_q   <= known_q ? rd_len_q : '0;
						st_q    <= S_WALK;
						if (32'(count_q) < DICT_DEPTH) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_WALK: begin
					if (pos_q == '0) begin
						k_q  <= '0;
						st_q <= S_WAIT;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				S_WAIT: st_q <= S_EMIT;
				S_EMIT: begin
					if (out_load) begin
						out_byte     <= stk_rd_q;
						last         <= (k_q + 1'b1 == total_q);
						phrase_error <= 1'b0;
						k_q          <= k_q + 1'b1;
						st_q         <= (k_q + 1'b1 == total_q) ? S_IDLE : S_WAIT;
					end
				end
				S_ERR: begin
					if (out_load) begin
						out_byte     <= ch_q;
						last         <= 1'b1;
						phrase_error <= 1'b1;
						st_q         <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign empty = !out_v_q;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DICT_DEPTH) else $error("entry count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pop) |=> out_v_q && $stable(out_byte)) else $error("result lost");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && phrase_error) |-> last) else $error("error without last");

endmodule

// ----- src/lz78_triple_decoder.sv -----
// lz78 token decoder
// input channel: push/full with prefix_index, new_char, new_stream; a request
// is one token. new_stream clears the dictionary before decoding that token.
// output channel: empty/pop with out_byte, last, phrase_error; one request per
// decoded byte, last marks the final byte of a token.
// a two-entry token queue decouples the input from the decoder.
// per token the decoder reads the prefix entry, walks the dictionary at one
// link per cycle to fill the phrase stack, then emits each byte through the
// registered phrase stack read; it takes the next token only after the last
// byte of the current one, and a held output stalls the emission.
// too long a phrase gives one byte with phrase_error and is not stored.
// reset clears the queue, the entry count and the output register; the
// dictionary memories need no clearing.
// when pop stays low the decoder holds its byte and stops; the queue fills
// and then full rises.
module lz78_triple_decoder
	import lz78_pkg::*;
#(
	parameter int DICT_DEPTH = DictDepthDef,
	parameter int MAX_PHRASE = MaxPhraseDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [IdxW-1:0]  prefix_index,
	input  logic [ByteW-1:0] new_char,
	input  logic             new_stream,
	output logic             empty,
	input  logic             pop,
	output logic [ByteW-1:0] out_byte,
	output logic             last,
	output logic             phrase_error
);

	logic      tok_valid, tok_take;
	lz78_tok_t tok;

	lz78_front u_front (
		.clk, .arst_n, .push, .full, .prefix_index, .new_char, .new_stream,
		.tok_valid, .tok_take, .tok
	);

	lz78_back #(.DICT_DEPTH(DICT_DEPTH), .MAX_PHRASE(MAX_PHRASE)) u_back (
		.clk, .arst_n, .tok_valid, .tok_take, .tok, .empty, .pop,
		.out_byte, .last, .phrase_error
	);

endmodule

// ----- tb/sv/lz78_phrase_checker.sv -----
module lz78_phrase_checker
	import lz78_pkg::*;
#(
	parameter int DICT_DEPTH = DictDepthDef,
	parameter int MAX_PHRASE = MaxPhraseDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  logic [IdxW-1:0]  prefix_index,
	input  logic [ByteW-1:0] new_char,
	input  logic             new_stream,
	input  logic             empty,
	input  logic             pop,
	input  logic [ByteW-1:0] out_byte,
	input  logic             last,
	input  logic             phrase_error,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ByteW-1:0] b;
		logic             fin;
		logic             err;
	} byte_req_t;

	logic [15:0]      link_mem [DICT_DEPTH];
	logic [ByteW-1:0] char_mem [DICT_DEPTH];
	int               len_mem  [DICT_DEPTH];
	int               stored;
	byte_req_t        byte_q [$];

	assign pending = byte_q.size();

	task automatic report(input string what, input logic [9:0] got, input logic [9:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic decode_token(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] ch,
			input logic clr);
		int        plen;
		int        lnk;
		int        e;
		byte_req_t r;
		logic [ByteW-1:0] stk [MAX_PHRASE];
		plen = 0;
		lnk = 0;
		if (clr)
			stored = 0;
		if (idx > 0 && idx <= stored && idx <= DICT_DEPTH) begin
			lnk = idx - 1;
			plen = len_mem[lnk];
		end
		if (plen + 1 > MAX_PHRASE) begin
			r = '{ch, 1'b1, 1'b1};
			byte_q.push_back(r);
			return;
		end
		stk[plen] = ch;
		e = lnk;
		for (int p = plen - 1; p >= 0; p--) begin
			stk[p] = char_mem[e];
			e = link_mem[e];
			if (e >= DICT_DEPTH)
				e = 0;
		end
		for (int k = 0; k <= plen; k++) begin
			r = '{stk[k], k == plen, 1'b0};
			byte_q.push_back(r);
		end
		if (stored < DICT_DEPTH) begin
			link_mem[stored] = 16'(lnk);
			char_mem[stored] = ch;
			len_mem[stored] = plen + 1;
			stored++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		byte_req_t w;
		if (!arst_n) begin
			stored = 0;
			fail_count = 0;
			byte_q.delete();
		end else begin
			if (pop && !empty) begin
				if (byte_q.size() == 0) begin
					report("unexpected byte", {out_byte, last, phrase_error}, '0);
				end else begin
					w = byte_q.pop_front();
					if (out_byte !== w.b)
						report("out_byte", 10'(out_byte), 10'(w.b));
					if (last !== w.fin)
						report("last", 10'(last), 10'(w.fin));
					if (phrase_error !== w.err)
						report("phrase_error", 10'(phrase_error), 10'(w.err));
				end
			end
			if (push && !full)
				decode_token(prefix_index, new_char, new_stream);
		end
	end
endmodule

// ----- tb/sv/tb_lz78_triple_decoder.sv -----
module tb_lz78_triple_decoder
	import lz78_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TokenCount = 360;
	localparam int CycleLimit = 400000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic [IdxW-1:0]  prefix_index = '0;
	logic [ByteW-1:0] new_char = '0;
	logic             new_stream = 1'b0;
	logic             empty;
	logic             pop = 1'b0;
	logic [ByteW-1:0] out_byte;
	logic             last;
	logic             phrase_error;
	int               fail_count;
	int               pending;
	int               cycles = 0;
	int               dict_size = 0;
	int               chain_tail = 0;
	int               chain_len = 0;
	bit               calm = 1'b0;
	bit               hold_pop = 1'b0;

	lz78_triple_decoder u_top (.*);

	lz78_phrase_checker u_check (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_pop)
			pop <= 1'b0;
		else
			pop <= calm || ($urandom_range(99) >= 11);
	end

	task automatic send_token(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] ch,
			input logic clr);
		if (!calm)
			while ($urandom_range(99) < 11) begin
				push <= 1'b0;
				@(posedge clk);
			end
		push <= 1'b1;
		prefix_index <= idx;
		new_char <= ch;
		new_stream <= clr;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (clr)
			dict_size = 0;
		if (dict_size < 4096)
			dict_size++;
	endtask

	task automatic random_token();
		int sel;
		logic [IdxW-1:0] idx;
		logic clr;
		sel = $urandom_range(99);
		clr = ($urandom_range(99) < 3);
		if (sel < 35 && chain_len > 0 && !clr) begin
			idx = 16'(chain_tail);
			chain_len++;
		end else if (sel < 75 && dict_size > 0) begin
			idx = 16'($urandom_range(dict_size));
		end else if (sel < 85) begin
			idx = 16'($urandom);
		end else begin
			idx = 0;
		end
		send_token(idx, 8'($urandom), clr);
		if (clr)
			chain_len = 0;
		if (idx == 0 || clr) begin
			chain_tail = dict_size;
			chain_len = 1;
		end else if (sel < 35) begin
			chain_tail = dict_size;
		end
		if (chain_len > 70)
			chain_len = 0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_token(16'h0000, 8'h00, 1'b1);
		send_token(16'h0001, 8'hff, 1'b0);
		send_token(16'h0002, 8'ha5, 1'b0);
		send_token(16'hffff, 8'h5a, 1'b0);
		send_token(16'h0004, 8'h0f, 1'b0);
		// grow one chain past the phrase bound
		send_token(16'h0000, 8'h11, 1'b1);
		for (int i = 1; i <= 66; i++)
			send_token(16'(i), 8'(i * 7), 1'b0);
		send_token(16'h0000, 8'hf0, 1'b1);
		fork
			begin
				hold_pop = 1'b1;
				repeat (400) @(posedge clk);
				hold_pop = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_token(i % 2 ? 16'h0001 : 16'h0000, 8'($urandom), 1'b0);
		join
		for (int i = 0; i < TokenCount; i++) begin
			calm = (i >= 150 && i < 220);
			random_token();
		end
		calm = 1'b1;
		send_token(16'd4096, 8'h77, 1'b0);
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
